// ===== design/itoa_pkg.sv =====
// Shared types, constants and helper functions for the integer to ASCII converter.
// No dependencies; compiled first.
package itoa_pkg;

  // field widths
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned CHAR_WIDTH  = 8;

  // decimal digits needed for the largest magnitude 2^(w-1)
  function automatic int unsigned dec_digits(input int unsigned w);
    logic [63:0] p;
    int unsigned n;
    p = 64'd1 << (w - 1);
    n = 0;
    while (p != 64'd0) begin
      p = p / 64'd10;
      n++;
    end
    return n;
  endfunction

  // digit counts per base
  localparam int unsigned DEC_DIGITS = dec_digits(VALUE_WIDTH);
  localparam int unsigned OCT_DIGITS = (VALUE_WIDTH + 2) / 3;
  localparam int unsigned HEX_DIGITS = (VALUE_WIDTH + 3) / 4;

  // digit shift register holds the bcd digits or the power-of-two digits
  localparam int unsigned SR_WIDTH  = 4 * DEC_DIGITS;
  localparam int unsigned BIN_SHIFT = SR_WIDTH - VALUE_WIDTH;
  localparam int unsigned OCT_SHIFT = SR_WIDTH - 3 * OCT_DIGITS;
  localparam int unsigned HEX_SHIFT = SR_WIDTH - 4 * HEX_DIGITS;
  localparam int unsigned CNT_WIDTH = $clog2(VALUE_WIDTH + 1);

  typedef logic [VALUE_WIDTH-1:0] value_t;
  typedef logic [SR_WIDTH-1:0]    sr_t;
  typedef logic [CNT_WIDTH-1:0]   cnt_t;
  typedef logic [CHAR_WIDTH-1:0]  char_t;
  typedef logic [3:0]             digit_t;

  typedef enum logic [1:0] {
    RADIX_BIN = 2'd0,
    RADIX_OCT = 2'd1,
    RADIX_DEC = 2'd2,
    RADIX_HEX = 2'd3
  } radix_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DABBLE,
    ST_SKIP,
    ST_EMIT
  } state_e;

  // ascii codes
  localparam char_t CHAR_MINUS   = 8'h2d;
  localparam char_t CHAR_ZERO    = 8'h30;
  localparam char_t CHAR_LOWER_A = 8'h61;

  // digit value to ascii, lower case hex
  function automatic char_t digit_char(input digit_t d);
    if (d < 4'd10) begin
      return CHAR_ZERO + {4'b0, d};
    end else begin
      return CHAR_LOWER_A + {4'b0, d} - 8'd10;
    end
  endfunction

  // add 3 to every bcd digit of 5 or more, ahead of the next shift
  function automatic sr_t dabble_adjust(input sr_t s);
    sr_t    r;
    digit_t dig;
    r = s;
    for (int i = 0; i < DEC_DIGITS; i++) begin
      dig = s[4*i +: 4];
      if (dig >= 4'd5) begin
        r[4*i +: 4] = dig + 4'd3;
      end
    end
    return r;
  endfunction

endpackage

// ===== design/itoa_if.sv =====
// Valid/ready channel interfaces for the converter's input and output.
// Depends on itoa_pkg.
interface itoa_in_if;
  logic                                       valid;
  logic                                       ready;
  logic signed [itoa_pkg::VALUE_WIDTH-1:0]    value;
  logic        [1:0]                          radix_code;

  modport source (output valid, output value, output radix_code, input ready);
  modport sink   (input valid, input value, input radix_code, output ready);
endinterface

interface itoa_out_if;
  logic                 valid;
  logic                 ready;
  itoa_pkg::char_t      char_code;
  logic                 last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink   (input valid, input char_code, input last, output ready);
endinterface

// ===== design/integer_to_ascii_radix_unit.sv =====
// Integer to ASCII converter top level: digit shift register, bit-serial
// binary to bcd stage and output register. Depends on itoa_pkg and itoa_if.
//
// Converts a 32-bit signed integer to its text in base 2, 8, 10 or 16, one
// character per output transaction, most significant digit first, with last
// set on the final character. Hex digits are lower case; base 10 prints a
// leading minus for negative values, other bases print the two's complement
// pattern. One number is converted at a time. Leading zeros are dropped one
// digit per cycle before the digits leave one per cycle while the output
// register is free. Base 10 first runs a double-dabble pass that takes one
// input bit per cycle. A new number is accepted while the last character of
// the previous one still waits in the output register. Output backpressure
// stalls the emission of characters.
module integer_to_ascii_radix_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  itoa_in_if.sink           in_i,
  itoa_out_if.source        out_o
);

  itoa_pkg::state_e  state_q, state_d;
  itoa_pkg::radix_e  radix_q, radix_d;
  itoa_pkg::sr_t     sr_q, sr_d;
  itoa_pkg::value_t  bin_q, bin_d;
  itoa_pkg::cnt_t    cnt_q, cnt_d;
  logic              sign_q, sign_d;
  logic              out_valid_q, out_valid_d;
  itoa_pkg::char_t   out_char_q, out_char_d;
  logic              out_last_q, out_last_d;

  itoa_pkg::value_t  val_u;
  itoa_pkg::value_t  mag;
  itoa_pkg::sr_t     val_ext;
  itoa_pkg::sr_t     sr_adj;
  itoa_pkg::sr_t     sr_shift;
  itoa_pkg::digit_t  digit;
  logic              out_free;

  assign val_u    = in_i.value;
  assign mag      = val_u[itoa_pkg::VALUE_WIDTH-1] ? (~val_u + 1'b1) : val_u;
  assign val_ext  = {{(itoa_pkg::SR_WIDTH - itoa_pkg::VALUE_WIDTH){1'b0}}, val_u};
  assign sr_adj   = itoa_pkg::dabble_adjust(sr_q);
  assign out_free = !out_valid_q || out_o.ready;

  // top digit of the shift register and the register after it leaves
  always_comb begin
    case (radix_q)
      itoa_pkg::RADIX_BIN: begin
        digit    = {3'b0, sr_q[itoa_pkg::SR_WIDTH-1]};
        sr_shift = sr_q << 1;
      end
      itoa_pkg::RADIX_OCT: begin
        digit    = {1'b0, sr_q[itoa_pkg::SR_WIDTH-1 -: 3]};
        sr_shift = sr_q << 3;
      end
      default: begin
        digit    = sr_q[itoa_pkg::SR_WIDTH-1 -: 4];
        sr_shift = sr_q << 4;
      end
    endcase
  end

  // next state and datapath control
  always_comb begin
    state_d     = state_q;
    radix_d     = radix_q;
    sr_d        = sr_q;
    bin_d       = bin_q;
    cnt_d       = cnt_q;
    sign_d      = sign_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    in_i.ready  = 1'b0;

    case (state_q)
      itoa_pkg::ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          radix_d = itoa_pkg::radix_e'(in_i.radix_code);
          sign_d  = 1'b0;
          case (itoa_pkg::radix_e'(in_i.radix_code))
            itoa_pkg::RADIX_DEC: begin
              sign_d  = val_u[itoa_pkg::VALUE_WIDTH-1];
              bin_d   = mag;
              sr_d    = '0;
              cnt_d   = itoa_pkg::cnt_t'(itoa_pkg::VALUE_WIDTH);
              state_d = itoa_pkg::ST_DABBLE;
            end
            itoa_pkg::RADIX_BIN: begin
              sr_d    = val_ext << itoa_pkg::BIN_SHIFT;
              cnt_d   = itoa_pkg::cnt_t'(itoa_pkg::VALUE_WIDTH);
              state_d = itoa_pkg::ST_SKIP;
            end
            itoa_pkg::RADIX_OCT: begin
              sr_d    = val_ext << itoa_pkg::OCT_SHIFT;
              cnt_d   = itoa_pkg::cnt_t'(itoa_pkg::OCT_DIGITS);
              state_d = itoa_pkg::ST_SKIP;
            end
            default: begin
              sr_d    = val_ext << itoa_pkg::HEX_SHIFT;
              cnt_d   = itoa_pkg::cnt_t'(itoa_pkg::HEX_DIGITS);
              state_d = itoa_pkg::ST_SKIP;
            end
          endcase
        end
      end

      // double dabble: one magnitude bit into the bcd digits per cycle
      itoa_pkg::ST_DABBLE: begin
        sr_d  = {sr_adj[itoa_pkg::SR_WIDTH-2:0], bin_q[itoa_pkg::VALUE_WIDTH-1]};
        bin_d = bin_q << 1;
        if (cnt_q == itoa_pkg::cnt_t'(1)) begin
          cnt_d   = itoa_pkg::cnt_t'(itoa_pkg::DEC_DIGITS);
          state_d = itoa_pkg::ST_SKIP;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end

      // drop leading zeros, keep the final digit so zero prints as one '0'
      itoa_pkg::ST_SKIP: begin
        if (digit == 4'd0 && cnt_q != itoa_pkg::cnt_t'(1)) begin
          sr_d  = sr_shift;
          cnt_d = cnt_q - 1'b1;
        end else begin
          state_d = itoa_pkg::ST_EMIT;
        end
      end

      // one character per cycle into the output register while it is free
      itoa_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (sign_q) begin
            out_char_d = itoa_pkg::CHAR_MINUS;
            out_last_d = 1'b0;
            sign_d     = 1'b0;
          end else begin
            out_char_d = itoa_pkg::digit_char(digit);
            out_last_d = (cnt_q == itoa_pkg::cnt_t'(1));
            sr_d       = sr_shift;
            cnt_d      = cnt_q - 1'b1;
            if (cnt_q == itoa_pkg::cnt_t'(1)) begin
              state_d = itoa_pkg::ST_IDLE;
            end
          end
        end
      end

      default: begin
        state_d = itoa_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= itoa_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      sign_q      <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      sign_q      <= sign_d;
      cnt_q       <= cnt_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    radix_q    <= radix_d;
    sr_q       <= sr_d;
    bin_q      <= bin_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  // output channel
  assign out_o.valid     = out_valid_q;
  assign out_o.char_code = out_char_q;
  assign out_o.last      = out_last_q;

endmodule

// ===== design/itoa_check.sv =====
// Port-level assertions for the integer to ASCII converter, bound to the top.
// Depends on itoa_pkg and integer_to_ascii_radix_unit.
module itoa_check (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input itoa_pkg::char_t  out_char_i,
  input logic             out_last_i
);

  // stalled output transaction holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_char_i) && $stable(out_last_i))
    else $error("output changed while stalled");

  // only digits, lower case hex letters and the minus sign leave the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_char_i >= 8'h30 && out_char_i <= 8'h39) ||
                    (out_char_i >= 8'h61 && out_char_i <= 8'h66) ||
                    out_char_i == itoa_pkg::CHAR_MINUS)
    else $error("illegal character code");

  // a minus sign is never the final character
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_char_i == itoa_pkg::CHAR_MINUS |-> !out_last_i)
    else $error("minus sign marked last");

  // one number at a time: no input right after a transaction is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input ready while a number is in conversion");

endmodule

bind integer_to_ascii_radix_unit itoa_check u_itoa_check (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_char_i  (out_o.char_code),
  .out_last_i  (out_o.last)
);
